### hdl/cmds_pkg.sv
`default_nettype none

package cmds_pkg;

  // Shared multiplier: signed operands wide enough for every unsigned 24-bit factor.
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;

  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Sine samples are Q1.15; table entries are the non-negative magnitudes.
  localparam int SINE_W  = 16;
  localparam int ENTRY_W = 15;

  typedef logic signed [SINE_W-1:0] sine_t;

  // Configuration register widths and indexes.
  localparam int STEP_W    = 32;
  localparam int GAIN_W    = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TONE_ONE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_TWO_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAIN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAIN    = 2'd3;

  localparam logic [STEP_W-1:0] TONE_ONE_STEP_RST = 32'd25064119;
  localparam logic [STEP_W-1:0] TONE_TWO_STEP_RST = 32'd16707417;
  localparam logic [GAIN_W-1:0] LEFT_GAIN_RST     = 15'd19661;
  localparam logic [GAIN_W-1:0] RIGHT_GAIN_RST    = 15'd22938;

  // Q32 coefficients: vibrato depth 0.004 rad in turns, slow phase ratios 0.002 and 0.0018.
  localparam int COEF_W = 24;

  localparam logic [COEF_W-1:0] VIB_DEPTH_COEF = 24'd2734261;
  localparam logic [COEF_W-1:0] SLOW_ONE_COEF  = 24'd8589935;
  localparam logic [COEF_W-1:0] SLOW_TWO_COEF  = 24'd7730941;

  // The slow step multiplies the increment in a low 24-bit and a high part.
  localparam int SPLIT_BITS  = 24;
  localparam int DELTA_SHIFT = 8;

endpackage

`default_nettype wire

### hdl/cmds_sine_rom.sv
`default_nettype none

module cmds_sine_rom #(
  parameter int DEPTH = 1024
) (
  input  wire                          clk_i,
  input  wire  [$clog2(DEPTH)+1:0]     idx_i,
  output logic signed [cmds_pkg::SINE_W-1:0] sine_o
);

  localparam int AW     = $clog2(DEPTH);
  localparam int ADDR_W = AW + 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Quarter-wave entry from an eight-term Taylor series in Q30, rounded to Q15.
  function automatic logic [cmds_pkg::ENTRY_W-1:0] sine_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    x    = (64'(i) * HALF_PI_Q30 + 64'(DEPTH / 2)) / DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k <= 7; k++) begin
      prod = (term * x2) >> 30;
      unique case (k)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        default: term = prod / 64'd210;
      endcase
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return cmds_pkg::ENTRY_W'(q);
  endfunction

  logic [cmds_pkg::ENTRY_W-1:0] table_w [DEPTH+1];

  for (genvar g = 0; g <= DEPTH; g++) begin : g_entry
    localparam logic [cmds_pkg::ENTRY_W-1:0] ENTRY = sine_entry(g);
    assign table_w[g] = ENTRY;
  end

  logic [1:0]                   quad;
  logic [AW-1:0]                offs;
  logic [ADDR_W-1:0]            addr;
  logic [cmds_pkg::ENTRY_W-1:0] entry_q;
  logic                         neg_q;

  assign quad = idx_i[AW+1:AW];
  assign offs = idx_i[AW-1:0];
  // Odd quadrants run the quarter wave backwards, from the quarter-turn endpoint.
  assign addr = quad[0] ? (ADDR_W'(DEPTH) - {1'b0, offs}) : {1'b0, offs};

  always_ff @(posedge clk_i) begin
    entry_q <= table_w[addr];
    neg_q   <= quad[1];
  end

  assign sine_o = neg_q ? -$signed({1'b0, entry_q}) : $signed({1'b0, entry_q});

endmodule

`default_nettype wire

### hdl/cross_modulated_dual_sine_synth.sv
// Cross-modulated dual sine synthesizer.
// Input stream (s_axis): one stereo frame per word, left and right samples in tdata,
// the end-of-buffer mark in tlast. Output stream (m_axis): the same frame with the
// tone of oscillator one added to left and of oscillator two added to right, both
// saturated, and tlast copied through.
// Configuration is a write-only port (cfg_we_i, cfg_idx_i, cfg_wdata_i): index 0 and 1
// are the oscillator base steps, 2 and 3 the left and right gains. Write it only while
// no frame is in flight.
// One multiplier and one sine table port serve all eight products and four lookups of
// a frame under a small sequencer. s_axis_tready_o is low from the acceptance of a frame
// until the sequencer is back in idle, so the block takes no new frame before it has
// finished the last. The finished frame sits in an output register, so the next frame
// may be accepted while m_axis still waits; a stalled receiver holds the block only
// when a second frame finishes before the first is taken.
// Reset clears all four phases to zero, loads the default steps and gains, and
// empties the output register. There is no clearing pass after reset.
`default_nettype none

module cross_modulated_dual_sine_synth #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 32,
  parameter int SAMPLE_BITS      = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: left_in, right_in
  input  wire  [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata_i,
  input  wire                                  s_axis_tlast_i,
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  // tdata: left_out, right_out
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata_o,
  output logic                                 m_axis_tlast_o,
  input  wire                                  cfg_we_i,
  input  wire  [cmds_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [cmds_pkg::STEP_W-1:0]          cfg_wdata_i
);

  localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH) + 2;
  localparam int LO_W   = (PHASE_BITS < cmds_pkg::SPLIT_BITS) ? PHASE_BITS
                                                              : cmds_pkg::SPLIT_BITS;
  localparam int SUM_W  = SAMPLE_BITS + 2;
  localparam int MIX_SH = 31 - SAMPLE_BITS;
  localparam int VIB_SH = 48 - PHASE_BITS;

  localparam cmds_pkg::prod_t MIX_RND = cmds_pkg::prod_t'(64'd1 << (MIX_SH - 1));
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MIX_L   = 4'd1;
  localparam logic [3:0] ST_MIX_R   = 4'd2;
  localparam logic [3:0] ST_VIB_RD  = 4'd3;
  localparam logic [3:0] ST_VIB_MUL = 4'd4;
  localparam logic [3:0] ST_INC     = 4'd5;
  localparam logic [3:0] ST_MAG     = 4'd6;
  localparam logic [3:0] ST_LO      = 4'd7;
  localparam logic [3:0] ST_HI      = 4'd8;
  localparam logic [3:0] ST_DELTA   = 4'd9;
  localparam logic [3:0] ST_SLOW    = 4'd10;
  localparam logic [3:0] ST_DONE    = 4'd11;

  // Rounds the Q30 tone product to the sample scale, adds it and saturates.
  function automatic logic signed [SAMPLE_BITS-1:0] mix_sat(
    input cmds_pkg::prod_t                p,
    input logic signed [SAMPLE_BITS-1:0]  x
  );
    cmds_pkg::prod_t         rnd;
    logic signed [SUM_W-1:0] tone;
    logic signed [SUM_W-1:0] y;
    rnd  = (p + MIX_RND) >>> MIX_SH;
    tone = SUM_W'(rnd);
    y    = SUM_W'(x) + tone;
    priority if (y > SAT_HI) begin
      mix_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (y < SAT_LO) begin
      mix_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      mix_sat = y[SAMPLE_BITS-1:0];
    end
  endfunction

  logic [3:0] state_q, state_d;
  logic       osc_q;

  logic [cmds_pkg::STEP_W-1:0] step1_q, step2_q;
  logic [cmds_pkg::GAIN_W-1:0] gain_l_q, gain_r_q;

  logic [PHASE_BITS-1:0] ph1_q, ph2_q, sl1_q, sl2_q;
  logic [PHASE_BITS-1:0] inc_q, inc_d, mag_q, delta_q;
  logic                  vneg_q, ineg_q;
  logic [cmds_pkg::COEF_W-1:0] frac_q;

  logic signed [SAMPLE_BITS-1:0] in_l_q, in_r_q, res_l_q, res_r_q, out_l_q, out_r_q;
  logic                          in_last_q, out_last_q, out_valid_q;

  cmds_pkg::prod_t   prod_q;
  cmds_pkg::mul_op_t mul_a, mul_b;
  logic [cmds_pkg::PROD_W-1:0] prod_u;

  cmds_pkg::sine_t             sine;
  logic [cmds_pkg::SINE_W-1:0] sine_mag;
  logic [IDX_W-1:0]            rom_idx;
  logic [PHASE_BITS-1:0]       rom_phase;

  logic [cmds_pkg::COEF_W-1:0] coef;
  logic [PHASE_BITS-1:0]       step_pb, vib_mag, vib_off, hi_part, slow_cur;
  logic [LO_W-1:0]             lo_part;

  logic s_fire, out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = DATA_W'({out_r_q, out_l_q});
  assign m_axis_tlast_o  = out_last_q;

  // Table port: main phases for the mix, then the other oscillator's slow phase.
  always_comb begin
    unique case (state_q)
      ST_MIX_L:  rom_phase = ph2_q;
      ST_VIB_RD: rom_phase = osc_q ? sl1_q : sl2_q;
      default:   rom_phase = ph1_q;
    endcase
  end

  assign rom_idx = rom_phase[PHASE_BITS-1 -: IDX_W];

  cmds_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .idx_i  (rom_idx),
    .sine_o (sine)
  );

  assign sine_mag = sine[cmds_pkg::SINE_W-1] ? unsigned'(-sine) : unsigned'(sine);

  assign coef     = osc_q ? cmds_pkg::SLOW_TWO_COEF : cmds_pkg::SLOW_ONE_COEF;
  assign step_pb  = PHASE_BITS'(osc_q ? step2_q : step1_q);
  assign lo_part  = mag_q[LO_W-1:0];
  assign hi_part  = mag_q >> cmds_pkg::SPLIT_BITS;
  assign slow_cur = osc_q ? sl2_q : sl1_q;
  assign prod_u   = unsigned'(prod_q);

  // Vibrato offset: twice the depth product, scaled down to the phase width.
  assign vib_mag = PHASE_BITS'({prod_u, 1'b0} >> VIB_SH);
  assign vib_off = vneg_q ? (-vib_mag) : vib_mag;
  assign inc_d   = step_pb + vib_off;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MIX_L: begin
        mul_a = cmds_pkg::mul_op_t'(sine);
        mul_b = cmds_pkg::mul_op_t'(gain_l_q);
      end
      ST_MIX_R: begin
        mul_a = cmds_pkg::mul_op_t'(sine);
        mul_b = cmds_pkg::mul_op_t'(gain_r_q);
      end
      ST_VIB_MUL: begin
        mul_a = cmds_pkg::mul_op_t'(sine_mag);
        mul_b = cmds_pkg::mul_op_t'(cmds_pkg::VIB_DEPTH_COEF);
      end
      ST_LO: begin
        mul_a = cmds_pkg::mul_op_t'(lo_part);
        mul_b = cmds_pkg::mul_op_t'(coef);
      end
      ST_HI: begin
        mul_a = cmds_pkg::mul_op_t'(hi_part);
        mul_b = cmds_pkg::mul_op_t'(coef);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (s_fire) state_d = ST_MIX_L;
      ST_MIX_L:   state_d = ST_MIX_R;
      ST_MIX_R:   state_d = ST_VIB_RD;
      ST_VIB_RD:  state_d = ST_VIB_MUL;
      ST_VIB_MUL: state_d = ST_INC;
      ST_INC:     state_d = ST_MAG;
      ST_MAG:     state_d = ST_LO;
      ST_LO:      state_d = ST_HI;
      ST_HI:      state_d = ST_DELTA;
      ST_DELTA:   state_d = ST_SLOW;
      ST_SLOW:    state_d = osc_q ? ST_DONE : ST_VIB_RD;
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      osc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      step1_q     <= cmds_pkg::TONE_ONE_STEP_RST;
      step2_q     <= cmds_pkg::TONE_TWO_STEP_RST;
      gain_l_q    <= cmds_pkg::LEFT_GAIN_RST;
      gain_r_q    <= cmds_pkg::RIGHT_GAIN_RST;
      ph1_q       <= '0;
      ph2_q       <= '0;
      sl1_q       <= '0;
      sl2_q       <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cmds_pkg::CFG_TONE_ONE_STEP: step1_q  <= cfg_wdata_i;
          cmds_pkg::CFG_TONE_TWO_STEP: step2_q  <= cfg_wdata_i;
          cmds_pkg::CFG_LEFT_GAIN:     gain_l_q <= cfg_wdata_i[cmds_pkg::GAIN_W-1:0];
          cmds_pkg::CFG_RIGHT_GAIN:    gain_r_q <= cfg_wdata_i[cmds_pkg::GAIN_W-1:0];
          default:                     step1_q  <= step1_q;
        endcase
      end

      if (s_fire) begin
        osc_q <= 1'b0;
      end else if (state_q == ST_SLOW) begin
        osc_q <= 1'b1;
      end

      if (state_q == ST_MAG) begin
        if (osc_q) begin
          ph2_q <= ph2_q + inc_q;
        end else begin
          ph1_q <= ph1_q + inc_q;
        end
      end

      if (state_q == ST_SLOW) begin
        if (osc_q) begin
          sl2_q <= ineg_q ? (slow_cur - delta_q) : (slow_cur + delta_q);
        end else begin
          sl1_q <= ineg_q ? (slow_cur - delta_q) : (slow_cur + delta_q);
        end
      end

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;

    if (s_fire) begin
      in_l_q    <= s_axis_tdata_i[SAMPLE_BITS-1:0];
      in_r_q    <= s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
      in_last_q <= s_axis_tlast_i;
    end

    if (state_q == ST_MIX_R) begin
      res_l_q <= mix_sat(prod_q, in_l_q);
    end
    if (state_q == ST_VIB_RD && !osc_q) begin
      res_r_q <= mix_sat(prod_q, in_r_q);
    end

    if (state_q == ST_VIB_MUL) begin
      vneg_q <= sine[cmds_pkg::SINE_W-1];
    end
    if (state_q == ST_INC) begin
      inc_q <= inc_d;
    end
    if (state_q == ST_MAG) begin
      ineg_q <= inc_q[PHASE_BITS-1];
      mag_q  <= inc_q[PHASE_BITS-1] ? (-inc_q) : inc_q;
    end
    if (state_q == ST_HI) begin
      frac_q <= cmds_pkg::COEF_W'(prod_u >> cmds_pkg::SPLIT_BITS);
    end
    if (state_q == ST_DELTA) begin
      delta_q <= PHASE_BITS'((prod_u + cmds_pkg::PROD_W'(frac_q)) >> cmds_pkg::DELTA_SHIFT);
    end

    if (state_q == ST_DONE && out_free) begin
      out_l_q    <= res_l_q;
      out_r_q    <= res_r_q;
      out_last_q <= in_last_q;
    end
  end

endmodule

`default_nettype wire

### hdl/cmds_checker.sv
`default_nettype none

module cmds_checker #(
  parameter int DATA_W = 32
) (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              s_axis_tvalid_i,
  input wire              s_axis_tready_o,
  input wire              m_axis_tvalid_o,
  input wire              m_axis_tready_i,
  input wire [DATA_W-1:0] m_axis_tdata_o,
  input wire              m_axis_tlast_o
);

  // A stalled output word holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // Only one frame is in work: no word is taken right after another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken back to back");

  // The sequencer is still busy partway through a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> ##4 !s_axis_tready_o)
    else $error("input ready too early in a frame");

  // A new output word appears exactly when the sequencer returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("output word appeared while busy");

endmodule

bind cross_modulated_dual_sine_synth cmds_checker #(
  .DATA_W (DATA_W)
) u_cmds_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
